// ===== rtl/core/md4_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// md4_pkg
// shared types, constants and step functions of the md4 hash engine
// ----------------------------------------------------------------------------
package md4_pkg;

  localparam int CountW = 61;
  localparam int StepW  = 6;
  localparam logic [StepW-1:0] NumSteps = 6'd48;

  localparam logic [31:0] InitA = 32'h67452301;
  localparam logic [31:0] InitB = 32'hEFCDAB89;
  localparam logic [31:0] InitC = 32'h98BADCFE;
  localparam logic [31:0] InitD = 32'h10325476;
  localparam logic [31:0] RoundK1 = 32'h5A827999;
  localparam logic [31:0] RoundK2 = 32'h6ED9EBA1;
  localparam logic [7:0]  PadMarker = 8'h80;

  localparam logic [1:0] RND_F = 2'd0;
  localparam logic [1:0] RND_G = 2'd1;
  localparam logic [1:0] RND_H = 2'd2;

  typedef struct packed {
    logic put_byte;
    logic pad_mark;
    logic len_write;
    logic len_clear;
    logic comp_start;
    logic emit;
  } md4_cmd_t;

  typedef struct packed {
    logic pos_last;
    logic pos_ge56;
    logic comp_done;
  } md4_sts_t;

  // message word index used by a step
  function automatic logic [3:0] md4_msg_idx(input logic [StepW-1:0] step);
    logic [3:0] idx;
    case (step[5:4])
      RND_F:   idx = step[3:0];
      RND_G:   idx = {step[1:0], step[3:2]};
      RND_H:   idx = {step[0], step[1], step[2], step[3]};
      default: idx = step[3:0];
    endcase
    return idx;
  endfunction

  // rotate amount used by a step
  function automatic logic [4:0] md4_shift(input logic [StepW-1:0] step);
    logic [4:0] s;
    case (step[5:4])
      RND_F: begin
        case (step[1:0])
          2'd0:    s = 5'd3;
          2'd1:    s = 5'd7;
          2'd2:    s = 5'd11;
          default: s = 5'd19;
        endcase
      end
      RND_G: begin
        case (step[1:0])
          2'd0:    s = 5'd3;
          2'd1:    s = 5'd5;
          2'd2:    s = 5'd9;
          default: s = 5'd13;
        endcase
      end
      default: begin
        case (step[1:0])
          2'd0:    s = 5'd3;
          2'd1:    s = 5'd9;
          2'd2:    s = 5'd11;
          default: s = 5'd15;
        endcase
      end
    endcase
    return s;
  endfunction

  function automatic logic [31:0] md4_rotl(input logic [31:0] x, input logic [4:0] s);
    logic [63:0] dbl;
    dbl = {x, x} << s;
    return dbl[63:32];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/md4_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// md4_in_if
// input channel: one optional message byte and an end-of-message flag
// ----------------------------------------------------------------------------
interface md4_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] msg_byte;
  logic       byte_valid;
  logic       last;

  modport source (output valid, msg_byte, byte_valid, last, input ready);
  modport sink (input valid, msg_byte, byte_valid, last, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/md4_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// md4_out_if
// result channel: the four digest words
// ----------------------------------------------------------------------------
interface md4_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word0;
  logic [31:0] digest_word1;
  logic [31:0] digest_word2;
  logic [31:0] digest_word3;

  modport source (output valid, digest_word0, digest_word1, digest_word2, digest_word3,
                  input ready);
  modport sink (input valid, digest_word0, digest_word1, digest_word2, digest_word3,
                output ready);
endinterface
`default_nettype wire

// ===== rtl/core/md4_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// md4_dp
// block buffer, byte counter, chaining words, one-step-per-cycle round unit
// and the digest output register
// ----------------------------------------------------------------------------
module md4_dp
  import md4_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [7:0]  msg_byte,
  input  wire md4_cmd_t    cmd,
  output md4_sts_t         sts,
  output logic [31:0]      digest_word0,
  output logic [31:0]      digest_word1,
  output logic [31:0]      digest_word2,
  output logic [31:0]      digest_word3
);

  logic [31:0]       block_r [16];
  logic [CountW-1:0] count_r;
  logic [31:0]       chain_r [4];
  logic [31:0]       work_r  [4];
  logic [StepW-1:0]  step_r;
  logic              busy_r;
  logic [31:0]       digest_r [4];

  logic [5:0]  pos;
  logic [3:0]  pos_w;
  logic [1:0]  pos_b;
  logic [63:0] bit_len;
  logic [31:0] keep_mask;
  logic [31:0] f_val;
  logic [31:0] x_val;
  logic [31:0] sum_val;
  logic [31:0] new_val;
  logic        stepping;

  assign pos     = count_r[5:0];
  assign pos_w   = pos[5:2];
  assign pos_b   = pos[1:0];
  assign bit_len = {count_r, 3'b000};

  always_comb begin
    case (pos_b)
      2'd0:    keep_mask = 32'h00000000;
      2'd1:    keep_mask = 32'h000000FF;
      2'd2:    keep_mask = 32'h0000FFFF;
      default: keep_mask = 32'h00FFFFFF;
    endcase
  end

  // round function on b, c, d of the rotating working set
  always_comb begin
    case (step_r[5:4])
      RND_F:   f_val = (work_r[1] & work_r[2]) | (~work_r[1] & work_r[3]);
      RND_G:   f_val = ((work_r[1] & work_r[2]) | (work_r[1] & work_r[3]) |
                        (work_r[2] & work_r[3])) + RoundK1;
      default: f_val = (work_r[1] ^ work_r[2] ^ work_r[3]) + RoundK2;
    endcase
  end

  assign x_val    = block_r[md4_msg_idx(step_r)];
  assign sum_val  = work_r[0] + f_val + x_val;
  assign new_val  = md4_rotl(sum_val, md4_shift(step_r));
  assign stepping = busy_r && (step_r != NumSteps);

  assign sts.pos_last  = (pos == 6'd63);
  assign sts.pos_ge56  = (pos >= 6'd56);
  assign sts.comp_done = busy_r && (step_r == NumSteps);

  // block buffer
  always_ff @(posedge clk) begin
    if (cmd.put_byte) begin
      block_r[pos_w][8*pos_b +: 8] <= msg_byte;
    end
    if (cmd.pad_mark) begin
      for (int k = 0; k < 16; k++) begin
        if (4'(k) == pos_w) begin
          block_r[k] <= (block_r[k] & keep_mask) | ({24'h0, PadMarker} << (8*pos_b));
        end else if (4'(k) > pos_w && !(cmd.len_write && k >= 14)) begin
          block_r[k] <= 32'h0;
        end
      end
    end
    if (cmd.len_clear) begin
      for (int k = 0; k < 14; k++) begin
        block_r[k] <= 32'h0;
      end
    end
    if (cmd.len_write || cmd.len_clear) begin
      block_r[14] <= bit_len[31:0];
      block_r[15] <= bit_len[63:32];
    end
  end

  // byte count, chaining words and round sequencing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      chain_r[0] <= InitA;
      chain_r[1] <= InitB;
      chain_r[2] <= InitC;
      chain_r[3] <= InitD;
      busy_r     <= 1'b0;
      step_r     <= '0;
    end else begin
      if (cmd.put_byte) begin
        count_r <= count_r + CountW'(1);
      end
      if (cmd.comp_start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (stepping) begin
        step_r <= step_r + StepW'(1);
      end else if (sts.comp_done) begin
        busy_r <= 1'b0;
        for (int k = 0; k < 4; k++) begin
          chain_r[k] <= chain_r[k] + work_r[k];
        end
      end
      if (cmd.emit) begin
        count_r    <= '0;
        chain_r[0] <= InitA;
        chain_r[1] <= InitB;
        chain_r[2] <= InitC;
        chain_r[3] <= InitD;
      end
    end
  end

  // working words rotate by one place each step
  always_ff @(posedge clk) begin
    if (cmd.comp_start) begin
      for (int k = 0; k < 4; k++) begin
        work_r[k] <= chain_r[k];
      end
    end else if (stepping) begin
      work_r[0] <= work_r[3];
      work_r[1] <= new_val;
      work_r[2] <= work_r[1];
      work_r[3] <= work_r[2];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      for (int k = 0; k < 4; k++) begin
        digest_r[k] <= chain_r[k];
      end
    end
  end

  assign digest_word0 = digest_r[0];
  assign digest_word1 = digest_r[1];
  assign digest_word2 = digest_r[2];
  assign digest_word3 = digest_r[3];

endmodule
`default_nettype wire

// ===== rtl/core/md4_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// md4_ctrl
// sequencer for byte intake, block compression, padding and digest output
// ----------------------------------------------------------------------------
module md4_ctrl
  import md4_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  input  wire logic     in_byte_valid,
  input  wire logic     in_last,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  input  wire md4_sts_t sts,
  output md4_cmd_t      cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_COMP = 3'd1;
  localparam logic [2:0] ST_PAD  = 3'd2;
  localparam logic [2:0] ST_LEN  = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  localparam logic [1:0] PH_DATA  = 2'd0;
  localparam logic [1:0] PH_PAD1  = 2'd1;
  localparam logic [1:0] PH_FINAL = 2'd2;

  logic [2:0] state_r, state_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic       last_r, last_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    last_nxt  = last_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.put_byte = in_byte_valid;
          if (in_byte_valid && sts.pos_last) begin
            cmd.comp_start = 1'b1;
            phase_nxt      = PH_DATA;
            last_nxt       = in_last;
            state_nxt      = ST_COMP;
          end else if (in_last) begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        cmd.pad_mark   = 1'b1;
        cmd.comp_start = 1'b1;
        state_nxt      = ST_COMP;
        if (sts.pos_ge56) begin
          phase_nxt = PH_PAD1;
        end else begin
          cmd.len_write = 1'b1;
          phase_nxt     = PH_FINAL;
        end
      end
      ST_LEN: begin
        cmd.len_clear  = 1'b1;
        cmd.comp_start = 1'b1;
        phase_nxt      = PH_FINAL;
        state_nxt      = ST_COMP;
      end
      ST_COMP: begin
        if (sts.comp_done) begin
          case (phase_r)
            PH_DATA: begin
              state_nxt = last_r ? ST_PAD : ST_IDLE;
              last_nxt  = 1'b0;
            end
            PH_PAD1:  state_nxt = ST_LEN;
            default:  state_nxt = ST_EMIT;
          endcase
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_DATA;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_no_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !sts.comp_done)
    else $error("compression finished while idle");

  a_emit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || out_ready))
    else $error("digest overwrote a pending result");

  a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_valid_r)
    else $error("digest not presented after emit");

  a_start_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.comp_start |=> (state_r == ST_COMP))
    else $error("compression started outside compress state");

endmodule
`default_nettype wire

// ===== rtl/core/md4_hash.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// md4_hash
// MD4 digest engine, one optional byte per transfer
// ----------------------------------------------------------------------------
// Input is accepted only while idle. A byte that completes a 64-byte block
// holds off input while the compression runs one of its 48 steps per cycle
// through a single round unit, then adds into the chaining words. A transfer
// with last set adds padding: the marker is placed, with the length unless the
// marker falls in the last eight bytes of a block, and the block is compressed;
// in that case a further block of zeros and the length is compressed. Then the
// digest register is loaded once the result slot is free. The digest waits
// there for its transfer while the next message already streams in.
module md4_hash
  import md4_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  md4_in_if.sink    in_chan,
  md4_out_if.source out_chan
);

  md4_cmd_t cmd;
  md4_sts_t sts;

  md4_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_chan.valid),
    .in_byte_valid (in_chan.byte_valid),
    .in_last       (in_chan.last),
    .in_ready      (in_chan.ready),
    .out_valid     (out_chan.valid),
    .out_ready     (out_chan.ready),
    .sts           (sts),
    .cmd           (cmd)
  );

  md4_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .msg_byte     (in_chan.msg_byte),
    .cmd          (cmd),
    .sts          (sts),
    .digest_word0 (out_chan.digest_word0),
    .digest_word1 (out_chan.digest_word1),
    .digest_word2 (out_chan.digest_word2),
    .digest_word3 (out_chan.digest_word3)
  );

endmodule
`default_nettype wire
